// ===== hdl/spbf_pkg.sv =====
`timescale 1ns / 1ps
package spbf_pkg;
    localparam int MaxVertices = 64;
    localparam int MaxEdges    = 1024;
    localparam int WeightBits  = 16;

    localparam logic [1:0] ST_PATH    = 2'd0;
    localparam logic [1:0] ST_UNREACH = 2'd1;
    localparam logic [1:0] ST_NEGCYC  = 2'd2;

    localparam logic [1:0] REG_VCOUNT = 2'd0;
    localparam logic [1:0] REG_START  = 2'd1;
    localparam logic [1:0] REG_TARGET = 2'd2;
endpackage

// ===== hdl/spbf_ram.sv =====
`timescale 1ns / 1ps
module spbf_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== hdl/shortest_path_bellman_ford.sv =====
`timescale 1ns / 1ps
// Bellman-Ford single-source shortest path engine.
// Items enter on i_start while o_busy is low. Kind 0 appends one edge
// (from, to, signed weight) to the edge memory, and loads can follow back
// to back; edges past the memory depth are dropped. Kind 1 runs the search
// over all loaded edges and then empties the edge memory. A run clears the
// distance and parent tables one vertex at a time, then makes up to
// vertex_count passes. Each edge is handled in turn: edge read, table
// lookup, then relaxation through the shared adder and comparator. The run
// stops after a pass with no change, or early on a negative cycle. Then the
// parent chain is walked back from the target into a path stack and played
// out one item per cycle after a setup state. A status item goes out
// instead through the S_STATUS state. o_valid marks each result for exactly
// one cycle; o_last marks the final one. The receiver cannot stall.
// Configuration writes use i_cfg_valid/o_cfg_ready, which is high while
// the block is idle. Reset returns registers to defaults and empties the
// edge memory; the tables are cleared at the start of every run.
module shortest_path_bellman_ford
    import spbf_pkg::*;
#(
    parameter int MAX_VERTICES = spbf_pkg::MaxVertices,
    parameter int MAX_EDGES    = spbf_pkg::MaxEdges,
    parameter int WEIGHT_BITS  = spbf_pkg::WeightBits
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    output logic         o_busy,
    input  logic         i_kind,
    input  logic [5:0]   i_edge_from,
    input  logic [5:0]   i_edge_to,
    input  logic signed [15:0] i_edge_weight,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [6:0]   i_cfg_data,
    output logic         o_valid,
    output logic [1:0]   o_status,
    output logic [5:0]   o_path_node,
    output logic signed [21:0] o_total_latency,
    output logic         o_last
);
    localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int VCW = $clog2(MAX_VERTICES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int ECW = $clog2(MAX_EDGES + 1);
    localparam int DW = VW + WEIGHT_BITS + 2;
    localparam int EW = 2 * VW + WEIGHT_BITS;
    localparam int TW = DW + 1;
    localparam int PW = VW + 1;
    localparam logic signed [DW-1:0] Bound =
        DW'(MAX_VERTICES) <<< (WEIGHT_BITS - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_CLEAR, S_PASS_START, S_PASS_RD, S_PASS_LK, S_PASS_EX,
        S_PASS_END, S_PASS_DEC, S_WALK_RD, S_WALK_PUSH, S_EMIT_RD, S_EMIT,
        S_STATUS
    } t_state;

    t_state r_state;
    logic [6:0] r_vcount;
    logic [5:0] r_start_node, r_target_node;
    logic [ECW-1:0] r_edge_total;
    logic [VCW-1:0] r_n;
    logic [VCW-1:0] r_pass;
    logic [ECW-1:0] r_eidx;
    logic r_changed, r_neg;
    logic [VW:0] r_vidx;
    logic [VW:0] r_count;
    logic [VW-1:0] r_cur;
    logic signed [DW-1:0] r_tdist;
    logic [1:0] r_st;

    logic r_valid;
    logic [1:0] r_ostatus;
    logic [5:0] r_onode;
    logic signed [21:0] r_olat;
    logic r_olast;

    logic e_we;
    logic [EAW-1:0] e_waddr, e_raddr;
    logic [EW-1:0] e_wdata, e_rdata;

    // Vertex table {reach, distance}, held twice so that the source and the
    // destination of an edge are looked up in the same cycle.
    logic v_we;
    logic [VW-1:0] v_waddr, va_raddr, vb_raddr;
    logic [TW-1:0] v_wdata, va_rdata, vb_rdata;

    // Parent table {valid, parent} and path stack.
    logic pa_we;
    logic [VW-1:0] pa_waddr, pa_raddr;
    logic [PW-1:0] pa_wdata, pa_rdata;
    logic sk_we;
    logic [VW-1:0] sk_waddr, sk_raddr, sk_wdata, sk_rdata;

    spbf_ram #(.Width(EW), .Depth(MAX_EDGES)) u_edges (
        .i_clk(i_clk), .i_we(e_we), .i_waddr(e_waddr), .i_wdata(e_wdata),
        .i_raddr(e_raddr), .o_rdata(e_rdata)
    );

    spbf_ram #(.Width(TW), .Depth(MAX_VERTICES)) u_vtab_a (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(va_raddr), .o_rdata(va_rdata)
    );

    spbf_ram #(.Width(TW), .Depth(MAX_VERTICES)) u_vtab_b (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(vb_raddr), .o_rdata(vb_rdata)
    );

    spbf_ram #(.Width(PW), .Depth(MAX_VERTICES)) u_parents (
        .i_clk(i_clk), .i_we(pa_we), .i_waddr(pa_waddr), .i_wdata(pa_wdata),
        .i_raddr(pa_raddr), .o_rdata(pa_rdata)
    );

    spbf_ram #(.Width(VW), .Depth(MAX_VERTICES)) u_stack (
        .i_clk(i_clk), .i_we(sk_we), .i_waddr(sk_waddr), .i_wdata(sk_wdata),
        .i_raddr(sk_raddr), .o_rdata(sk_rdata)
    );

    logic accept;
    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);

    assign e_we = accept && !i_kind && (r_edge_total < ECW'(MAX_EDGES));
    assign e_waddr = r_edge_total[EAW-1:0];
    assign e_wdata = {i_edge_from[VW-1:0], i_edge_to[VW-1:0],
                      i_edge_weight[WEIGHT_BITS-1:0]};
    assign e_raddr = r_eidx[EAW-1:0];

    // Decode the edge that the memory presents and the looked-up distances.
    logic [VW-1:0] ed_u, ed_v;
    logic signed [WEIGHT_BITS-1:0] ed_w;
    logic reach_u, reach_v;
    logic signed [DW-1:0] dist_u, dist_v;
    logic in_range;
    logic signed [DW-1:0] cand, cand_sat;
    logic too_low;
    logic take;
    logic relax;
    logic clr_reach;
    assign ed_u = e_rdata[EW-1 -: VW];
    assign ed_v = e_rdata[WEIGHT_BITS +: VW];
    assign ed_w = e_rdata[WEIGHT_BITS-1:0];
    assign reach_u = va_rdata[DW];
    assign dist_u = va_rdata[DW-1:0];
    assign reach_v = vb_rdata[DW];
    assign dist_v = vb_rdata[DW-1:0];
    assign in_range = ({1'b0, ed_u} < (VW+1)'(r_n)) && ({1'b0, ed_v} < (VW+1)'(r_n))
                      && reach_u;
    assign cand = dist_u + DW'(ed_w);
    assign cand_sat = (cand > Bound) ? Bound : cand;
    assign too_low = (cand < -Bound);
    assign take = !reach_v || (cand_sat < dist_v);
    assign relax = (r_state == S_PASS_EX) && in_range && !too_low && take;
    assign clr_reach = (r_vidx[VW-1:0] == r_start_node[VW-1:0]) &&
                       (7'(r_start_node) < 7'(r_n));

    // Table writes come from the clearing pass or from a relaxed edge.
    assign v_we = (r_state == S_CLEAR) || relax;
    assign v_waddr = (r_state == S_CLEAR) ? r_vidx[VW-1:0] : ed_v;
    assign v_wdata = (r_state == S_CLEAR) ? {clr_reach, {DW{1'b0}}} : {1'b1, cand_sat};
    assign va_raddr = ed_u;
    assign vb_raddr = (r_state == S_PASS_LK) ? ed_v : r_target_node[VW-1:0];

    assign pa_we = (r_state == S_CLEAR) || relax;
    assign pa_waddr = v_waddr;
    assign pa_wdata = (r_state == S_CLEAR) ? {PW{1'b0}} : {1'b1, ed_u};
    assign pa_raddr = r_cur;

    // The stack is read one entry ahead while the path plays out.
    assign sk_we = (r_state == S_WALK_PUSH);
    assign sk_waddr = r_count[VW-1:0];
    assign sk_wdata = r_cur;
    assign sk_raddr = (r_state == S_EMIT) ? (r_count[VW-1:0] - VW'(2))
                                          : (r_count[VW-1:0] - VW'(1));

    logic [VCW-1:0] n_clamped;
    always_comb begin
        if (r_vcount == 7'd0) begin
            n_clamped = VCW'(1);
        end else if (32'(r_vcount) > MAX_VERTICES) begin
            n_clamped = VCW'(MAX_VERTICES);
        end else begin
            n_clamped = VCW'(r_vcount);
        end
    end

    // Sequencer and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vcount <= 7'd64;
            r_start_node <= '0;
            r_target_node <= '0;
            r_edge_total <= '0;
            r_valid <= 1'b0;
            r_ostatus <= ST_PATH;
            r_onode <= '0;
            r_olat <= '0;
            r_olast <= 1'b0;
        end else begin
            r_valid <= (r_state == S_EMIT) || (r_state == S_STATUS);
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        case (i_cfg_index)
                            REG_VCOUNT: r_vcount <= i_cfg_data;
                            REG_START:  r_start_node <= i_cfg_data[5:0];
                            REG_TARGET: r_target_node <= i_cfg_data[5:0];
                            default: ;
                        endcase
                    end
                    if (accept) begin
                        if (!i_kind) begin
                            if (e_we) begin
                                r_edge_total <= r_edge_total + 1'b1;
                            end
                        end else begin
                            r_n <= n_clamped;
                            r_vidx <= '0;
                            r_neg <= 1'b0;
                            r_pass <= VCW'(1);
                            r_state <= S_CLEAR;
                        end
                    end
                end
                // Clear one vertex per cycle and seed the start vertex.
                S_CLEAR: begin
                    if (r_vidx == (VW+1)'(MAX_VERTICES - 1)) begin
                        r_state <= S_PASS_START;
                    end
                    r_vidx <= r_vidx + 1'b1;
                end
                S_PASS_START: begin
                    r_eidx <= '0;
                    r_changed <= 1'b0;
                    r_state <= (r_edge_total == '0) ? S_PASS_END : S_PASS_RD;
                end
                S_PASS_RD: begin
                    r_state <= S_PASS_LK;
                end
                S_PASS_LK: begin
                    r_state <= S_PASS_EX;
                end
                // Relax one edge through the shared adder and comparator.
                S_PASS_EX: begin
                    if (in_range && too_low) begin
                        r_neg <= 1'b1;
                        r_state <= S_PASS_END;
                    end else begin
                        if (relax) begin
                            r_changed <= 1'b1;
                        end
                        r_eidx <= r_eidx + 1'b1;
                        r_state <= (r_eidx + 1'b1 == r_edge_total) ? S_PASS_END
                                                                   : S_PASS_RD;
                    end
                end
                // Wait for the target lookup to see the last write of the pass.
                S_PASS_END: begin
                    r_state <= S_PASS_DEC;
                end
                S_PASS_DEC: begin
                    r_count <= '0;
                    r_cur <= r_target_node[VW-1:0];
                    r_tdist <= dist_v;
                    if (r_neg) begin
                        r_st <= ST_NEGCYC;
                        r_state <= S_STATUS;
                    end else if (r_pass == r_n && r_changed) begin
                        r_st <= ST_NEGCYC;
                        r_state <= S_STATUS;
                    end else if (r_changed) begin
                        r_pass <= r_pass + 1'b1;
                        r_state <= S_PASS_START;
                    end else if (7'(r_target_node) >= 7'(r_n) || !reach_v) begin
                        r_st <= ST_UNREACH;
                        r_state <= S_STATUS;
                    end else begin
                        r_state <= S_WALK_RD;
                    end
                end
                // Walk parents back from the target into the stack.
                S_WALK_RD: begin
                    if (r_count == (VW+1)'(MAX_VERTICES)) begin
                        r_st <= ST_NEGCYC;
                        r_state <= S_STATUS;
                    end else begin
                        r_state <= S_WALK_PUSH;
                    end
                end
                S_WALK_PUSH: begin
                    r_count <= r_count + 1'b1;
                    if (pa_rdata[VW]) begin
                        r_cur <= pa_rdata[VW-1:0];
                        r_state <= S_WALK_RD;
                    end else begin
                        r_state <= S_EMIT_RD;
                    end
                end
                S_EMIT_RD: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    r_ostatus <= ST_PATH;
                    r_onode <= 6'(sk_rdata);
                    r_olat <= 22'(r_tdist);
                    r_olast <= (r_count == (VW+1)'(1));
                    r_count <= r_count - 1'b1;
                    if (r_count == (VW+1)'(1)) begin
                        r_edge_total <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_STATUS: begin
                    r_ostatus <= r_st;
                    r_onode <= '0;
                    r_olat <= '0;
                    r_olast <= 1'b1;
                    r_edge_total <= '0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid = r_valid;
    assign o_status = r_ostatus;
    assign o_path_node = r_onode;
    assign o_total_latency = r_olat;
    assign o_last = r_olast;
endmodule

// ===== hdl/spbf_checker.sv =====
`timescale 1ns / 1ps
module spbf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_busy,
    input logic       o_cfg_ready,
    input logic       o_valid,
    input logic [1:0] o_status,
    input logic       o_last
);
    // Results other than the final one only come out while a run is in progress.
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last |-> o_busy) else $error("result outside a run");
    // A status item is always the final item.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != 2'd0 |-> o_last) else $error("status not last");
    // The final item ends the run.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !o_busy) else $error("busy after last");
    // Configuration is taken only while idle.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready == !o_busy) else $error("config ready while busy");
    // Status 3 is never produced.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status != 2'd3) else $error("bad status");
endmodule

bind shortest_path_bellman_ford spbf_checker u_spbf_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_busy(o_busy),
    .o_cfg_ready(o_cfg_ready), .o_valid(o_valid), .o_status(o_status),
    .o_last(o_last)
);
